// File: sv/adaptive_range_bucket_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range bucket classifier
// Macros that wrap concurrent assertions; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_RANGE_BUCKET_CLASSIFIER_MACROS_SVH
`define ADAPTIVE_RANGE_BUCKET_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define ARBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ARBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ARBC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ARBC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/arbc_pkg.sv
// ----------------------------------------------------------------------------
// Range bucket classifier package
// Shared widths, command codes, op codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package arbc_pkg;
  localparam int unsigned DefCapacity = 128;
  localparam int unsigned ValW = 32;
  localparam int unsigned TgtW = 7;
  localparam logic [TgtW-1:0] TgtReset = 7'd8;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_COLLAPSE = 2'd2,
    CMD_CLASSIFY = 2'd3
  } cmd_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,      // latch the request
    OP_CLEAR,     // empty the table
    OP_ADD_STEP,  // one entry of the add search
    OP_SET_DROP,  // flag a lost value
    OP_INS_INIT,  // point at the insert position
    OP_INS_STEP,  // one entry of the insert shift
    OP_CLS_INIT,  // point at the second entry
    OP_CLS_STEP,  // one entry of the classify scan
    OP_MIN_INIT,  // start the smallest span search
    OP_MIN_STEP,  // one entry of the smallest span search
    OP_MRG_HEAD,  // write the merged range end
    OP_MRG_STEP   // one entry of the merge shift
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic zero_val;  // latched value is zero
    logic empty;     // table is empty
    logic few;       // at most one range
    logic ge;        // entry start at or above the value
    logic le;        // entry start at or below the value
    logic last;      // pointer is on the last valid entry
    logic at_end;    // pointer has reached the count
    logic found;     // add found an equal start
    logic full;      // table is full
    logic over;      // count above target
    cmd_t cmd;       // latched command
  } ctl_sts_t;
endpackage

// File: sv/arbc_datapath.sv
// ----------------------------------------------------------------------------
// Range bucket classifier datapath
// Range table memories, scan pointers, comparators and result registers.
// ----------------------------------------------------------------------------
module arbc_datapath #(
  parameter int unsigned CAPACITY = arbc_pkg::DefCapacity
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  arbc_pkg::cmd_t                  in_cmd,
  input  logic [arbc_pkg::ValW-1:0]       in_val,
  input  logic [arbc_pkg::TgtW-1:0]       target,
  input  arbc_pkg::ctl_cmd_t              ctl,
  output arbc_pkg::ctl_sts_t              sts,
  output logic [6:0]                      class_index,
  output logic [7:0]                      bucket_total,
  output logic                            dropped
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned W = arbc_pkg::ValW;

  logic [W-1:0]  lo_mem [CAPACITY];
  logic [W-1:0]  hi_mem [CAPACITY];
  logic [W-1:0]  lo_q_r, hi_q_r;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [W-1:0]  wlo, whi;
  logic          wlo_en, whi_en;

  arbc_pkg::cmd_t cmd_r;
  logic [W-1:0]  val_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;     // scan pointer
  logic [CW-1:0] pos_r, pos_nxt;     // insert position / best pair
  logic          have_r, have_nxt;
  logic [W-1:0]  best_r, best_nxt;
  logic [W-1:0]  prev_lo_r, prev_lo_nxt;
  logic [W-1:0]  carry_lo_r, carry_lo_nxt, carry_hi_r, carry_hi_nxt;
  logic          found_r, found_nxt;
  logic          drop_r, drop_nxt;
  logic [6:0]    cls_r, cls_nxt;
  logic [7:0]    tgt_eff;
  logic [W-1:0]  span;

  assign tgt_eff = (target == '0) ? 8'd1 : {1'b0, target};
  assign span = hi_q_r - prev_lo_r;

  // The read address follows the next pointer, so the read data always holds
  // the entry under the current pointer.
  assign raddr = AW'(ptr_nxt);

  always_ff @(posedge clk) begin
    if (wlo_en) lo_mem[waddr] <= wlo;
    if (whi_en) hi_mem[waddr] <= whi;
    lo_q_r <= lo_mem[raddr];
    hi_q_r <= hi_mem[raddr];
  end

  always_comb begin
    used_nxt = used_r; ptr_nxt = ptr_r; pos_nxt = pos_r; have_nxt = have_r;
    best_nxt = best_r; prev_lo_nxt = prev_lo_r; carry_lo_nxt = carry_lo_r;
    carry_hi_nxt = carry_hi_r; found_nxt = found_r; drop_nxt = drop_r;
    cls_nxt = cls_r;
    waddr = '0; wlo = '0; whi = '0; wlo_en = 1'b0; whi_en = 1'b0;
    unique case (ctl.op)
      arbc_pkg::OP_NONE: ;
      arbc_pkg::OP_LOAD: begin
        drop_nxt = 1'b0; cls_nxt = '0; found_nxt = 1'b0;
        pos_nxt = '0; ptr_nxt = '0;
      end
      arbc_pkg::OP_CLEAR: used_nxt = '0;
      arbc_pkg::OP_ADD_STEP: begin
        // The table is sorted, so the first start not below the value is
        // both the insert position and the only possible equal start.
        if (sts.ge) begin
          pos_nxt = ptr_r; found_nxt = (lo_q_r == val_r);
        end else begin
          pos_nxt = ptr_r + CW'(1); ptr_nxt = ptr_r + CW'(1);
        end
      end
      arbc_pkg::OP_SET_DROP: drop_nxt = 1'b1;
      arbc_pkg::OP_INS_INIT: ptr_nxt = pos_r;
      arbc_pkg::OP_INS_STEP: begin
        // Walk up from pos carrying the displaced entry one place higher.
        wlo_en = 1'b1; whi_en = 1'b1; waddr = AW'(ptr_r);
        if (ptr_r == pos_r) begin
          wlo = val_r; whi = val_r;
        end else begin
          wlo = carry_lo_r; whi = carry_hi_r;
        end
        carry_lo_nxt = lo_q_r; carry_hi_nxt = hi_q_r;
        if (sts.at_end) used_nxt = used_r + CW'(1);
        else ptr_nxt = ptr_r + CW'(1);
      end
      arbc_pkg::OP_CLS_INIT: ptr_nxt = CW'(1);
      arbc_pkg::OP_CLS_STEP: begin
        if (sts.le) cls_nxt = cls_r + 7'd1;
        if (!sts.last) ptr_nxt = ptr_r + CW'(1);
      end
      arbc_pkg::OP_MIN_INIT: begin
        ptr_nxt = '0; have_nxt = 1'b0;
      end
      arbc_pkg::OP_MIN_STEP: begin
        // The pair under test is (ptr-1, ptr); ties keep the earlier pair.
        if (ptr_r != '0 && (!have_r || span < best_r)) begin
          best_nxt = span; pos_nxt = ptr_r - CW'(1); have_nxt = 1'b1;
          carry_hi_nxt = hi_q_r;
        end
        prev_lo_nxt = lo_q_r;
        if (!sts.last) ptr_nxt = ptr_r + CW'(1);
      end
      arbc_pkg::OP_MRG_HEAD: begin
        whi_en = 1'b1; waddr = AW'(pos_r); whi = carry_hi_r;
        ptr_nxt = pos_r + CW'(2);
      end
      arbc_pkg::OP_MRG_STEP: begin
        if (sts.at_end) used_nxt = used_r - CW'(1);
        else begin
          wlo_en = 1'b1; whi_en = 1'b1; waddr = AW'(ptr_r - CW'(1));
          wlo = lo_q_r; whi = hi_q_r;
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0; ptr_r <= '0; found_r <= 1'b0; drop_r <= 1'b0; cls_r <= '0;
    end else begin
      used_r <= used_nxt; ptr_r <= ptr_nxt; found_r <= found_nxt;
      drop_r <= drop_nxt; cls_r <= cls_nxt;
    end
    pos_r <= pos_nxt; have_r <= have_nxt; best_r <= best_nxt;
    prev_lo_r <= prev_lo_nxt; carry_lo_r <= carry_lo_nxt; carry_hi_r <= carry_hi_nxt;
    if (ctl.op == arbc_pkg::OP_LOAD) begin
      cmd_r <= in_cmd; val_r <= in_val;
    end
  end

  always_comb begin
    sts.cmd = cmd_r;
    sts.zero_val = (val_r == '0);
    sts.empty = (used_r == '0);
    sts.few = (used_r <= CW'(1));
    sts.ge = (lo_q_r >= val_r);
    sts.le = (lo_q_r <= val_r);
    sts.last = ((CW+1)'(ptr_r) + (CW+1)'(1)) >= (CW+1)'(used_r);
    sts.at_end = (ptr_r >= used_r);
    sts.found = found_r;
    sts.full = (used_r >= CW'(CAPACITY));
    sts.over = (8'(used_r) > tgt_eff) && (used_r >= CW'(2));
  end

  assign class_index = cls_r;
  assign bucket_total = 8'(used_r);
  assign dropped = drop_r;
endmodule

// File: sv/arbc_ctrl.sv
// ----------------------------------------------------------------------------
// Range bucket classifier controller
// Sequences the table scans for each request and owns the handshakes.
// ----------------------------------------------------------------------------
`include "adaptive_range_bucket_classifier_macros.svh"
module arbc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                idle,
  input  arbc_pkg::ctl_sts_t  sts,
  output arbc_pkg::ctl_cmd_t  ctl
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ADD_SCAN, S_INS_CHK, S_INS, S_COL_TEST, S_MIN,
    S_MRG_HEAD, S_MRG, S_CLS, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // The result register frees once taken; a new request waits for it.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign idle = (state_r == S_IDLE) && !out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.op = arbc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid && !in_stall) begin
        ctl.op = arbc_pkg::OP_LOAD; state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.cmd)
          arbc_pkg::CMD_CLEAR: begin
            ctl.op = arbc_pkg::OP_CLEAR; state_nxt = S_DONE;
          end
          arbc_pkg::CMD_ADD: begin
            if (sts.zero_val) state_nxt = S_DONE;
            else if (sts.empty) state_nxt = S_INS_CHK;
            else state_nxt = S_ADD_SCAN;
          end
          arbc_pkg::CMD_COLLAPSE: state_nxt = S_COL_TEST;
          arbc_pkg::CMD_CLASSIFY: begin
            if (sts.few) state_nxt = S_DONE;
            else begin
              ctl.op = arbc_pkg::OP_CLS_INIT; state_nxt = S_CLS;
            end
          end
        endcase
      end
      S_ADD_SCAN: begin
        ctl.op = arbc_pkg::OP_ADD_STEP;
        if (sts.ge || sts.last) state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        if (sts.found) state_nxt = S_DONE;
        else if (sts.full) begin
          ctl.op = arbc_pkg::OP_SET_DROP; state_nxt = S_DONE;
        end else begin
          ctl.op = arbc_pkg::OP_INS_INIT; state_nxt = S_INS;
        end
      end
      S_INS: begin
        ctl.op = arbc_pkg::OP_INS_STEP;
        if (sts.at_end) state_nxt = S_DONE;
      end
      S_COL_TEST: begin
        if (sts.over) begin
          ctl.op = arbc_pkg::OP_MIN_INIT; state_nxt = S_MIN;
        end else state_nxt = S_DONE;
      end
      S_MIN: begin
        ctl.op = arbc_pkg::OP_MIN_STEP;
        if (sts.last) state_nxt = S_MRG_HEAD;
      end
      S_MRG_HEAD: begin
        ctl.op = arbc_pkg::OP_MRG_HEAD; state_nxt = S_MRG;
      end
      S_MRG: begin
        ctl.op = arbc_pkg::OP_MRG_STEP;
        if (sts.at_end) state_nxt = S_COL_TEST;
      end
      S_CLS: begin
        ctl.op = arbc_pkg::OP_CLS_STEP;
        if (!sts.le || sts.last) state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  `ARBC_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, in_stall)
  `ARBC_ASSERT_NXT(a_done_valid, clk, rst_n, state_r == S_DONE, out_valid)
  `ARBC_ASSERT_NXT(a_load_dispatch, clk, rst_n, ctl.op == arbc_pkg::OP_LOAD, state_r == S_DISPATCH)
endmodule

// File: sv/adaptive_range_bucket_classifier.sv
// ----------------------------------------------------------------------------
// Adaptive range bucket classifier
// Sorted range table with clear, add, collapse and classify requests.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_command, in_value
// out_    | output    | out_valid/out_stall| out_class_index, out_bucket_total,
//         |           |                    | out_dropped
// cfg_    | input     | cfg_valid/cfg_ready| cfg_target_buckets
//
// A request walks the range table one entry per cycle through a single
// registered read port. Reset is synchronous and needs no clearing pass. A
// new request is taken at the earliest on the edge where the previous result
// leaves the output register.
// ----------------------------------------------------------------------------
module adaptive_range_bucket_classifier #(
  parameter int unsigned CAPACITY = arbc_pkg::DefCapacity
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_class_index,
  output logic [7:0]  out_bucket_total,
  output logic        out_dropped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_target_buckets
);
  arbc_pkg::ctl_cmd_t ctl;
  arbc_pkg::ctl_sts_t sts;
  logic               idle;
  logic [6:0]         target_r;

  // Target register; written only between requests.
  assign cfg_ready = idle;
  always_ff @(posedge clk) begin
    if (!rst_n) target_r <= arbc_pkg::TgtReset;
    else if (cfg_valid && cfg_ready) target_r <= cfg_target_buckets;
  end

  arbc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .idle,
    .sts, .ctl
  );

  arbc_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst_n,
    .in_cmd(arbc_pkg::cmd_t'(in_command)), .in_val(in_value),
    .target(target_r), .ctl, .sts,
    .class_index(out_class_index), .bucket_total(out_bucket_total),
    .dropped(out_dropped)
  );
endmodule
